/* rtl/core/sorted_priority_queue_assert.svh */
// Assertion macros shared by the sorted priority queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge of aclk while out of reset.
`define SPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising edge of aclk, including during reset.
`define SPQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`else

`define SPQ_ASSERT(label, prop, msg)

`define SPQ_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

/* rtl/core/spq_pkg.sv */
// Types, constants and helpers shared by the sorted priority queue modules.
package spq_pkg;

    localparam int QUEUE_SLOTS = 64;
    localparam int CAPACITY    = QUEUE_SLOTS - 1;
    localparam int CNT_W       = $clog2(QUEUE_SLOTS);
    localparam int ENTRY_W     = 16;
    localparam int TREE_FANIN  = 8;
    localparam int TREE_LEVELS = (CAPACITY <= 8)   ? 1 :
                                 (CAPACITY <= 64)  ? 2 :
                                 (CAPACITY <= 512) ? 3 : 4;
    localparam int TREE_LEAVES = TREE_FANIN ** TREE_LEVELS;
    localparam int TREE_NODES  = TREE_LEAVES / TREE_FANIN;
    localparam int WAIT_W      = $clog2(TREE_LEVELS + 1);

    localparam logic [1:0] REQ_PUSH      = 2'd0;
    localparam logic [1:0] REQ_POP_FRONT = 2'd1;
    localparam logic [1:0] REQ_POP_BACK  = 2'd2;
    localparam logic [1:0] REQ_PEEK_BACK = 2'd3;

    typedef struct packed {
        logic [7:0]        id;
        logic signed [7:0] prio;
    } entry_t;

    typedef struct packed {
        logic             push;
        logic             pop_front;
        entry_t           new_entry;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] tail_idx;
    } cell_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_WAIT
    } state_t;

    // Count as reported on the result port: the low six bits.
    function automatic logic [5:0] count_field(input logic [CNT_W-1:0] c);
        logic [CNT_W+5:0] wide;
        wide = {6'b0, c};
        return wide[5:0];
    endfunction

endpackage

/* rtl/core/sorted_priority_queue.sv */
// Top level of the sorted priority queue: cell chain, back-entry tree and request control.
// Push, pop front and any request on an empty queue: result valid in the cycle after acceptance.
// Pop back and peek back on a nonempty queue: the request waits in ST_WAIT while the
// registered OR tree for the back entry settles and until the result register is free.
// One item is in work at a time; push and pop front sustain one item every cycle while m_ready is high.
// Reset clears the entry count and the handshake state; cell contents are not cleared.
`include "sorted_priority_queue_assert.svh"

module sorted_priority_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_req_type,
    input  logic [7:0]        s_entry_id,
    input  logic signed [6:0] s_base_priority,
    input  logic signed [5:0] s_nice_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_ok,
    output logic [7:0]        m_out_entry,
    output logic signed [7:0] m_out_priority,
    output logic [5:0]        m_count,
    output logic              m_empty_res
);
    import spq_pkg::*;

    // Control state.
    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic [WAIT_W-1:0] wait_reg;
    logic [WAIT_W-1:0] wait_next;
    logic              pend_pop_reg;
    logic              pend_pop_next;

    // Result register.
    logic              m_valid_reg;
    logic              m_valid_next;
    logic              m_ok_reg;
    logic              m_ok_next;
    entry_t            m_entry_reg;
    entry_t            m_entry_next;
    logic [5:0]        m_count_reg;
    logic [5:0]        m_count_next;
    logic              m_empty_reg;
    logic              m_empty_next;

    logic              s_fire;
    logic              out_free;
    logic              full;
    logic              empty;
    entry_t            new_entry;
    cell_ctrl_t        ctrl;

    entry_t            cell_q    [CAPACITY];
    logic              after_q   [CAPACITY];
    entry_t            tail_leaf [CAPACITY];
    entry_t            tail_entry;

    // The result register frees up when it is empty or its item is being taken.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign s_fire   = s_valid && s_ready;

    assign full  = fill_reg == CNT_W'(CAPACITY);
    assign empty = fill_reg == '0;

    // Combined priority always fits in eight bits, so a plain signed add does.
    assign new_entry.id   = s_entry_id;
    assign new_entry.prio = 8'(s_base_priority) + 8'(s_nice_value);

    // Every cell sees the same control word; the back is the cell at count minus one.
    always_comb begin
        ctrl.push      = s_fire && (s_req_type == REQ_PUSH) && !full;
        ctrl.pop_front = s_fire && (s_req_type == REQ_POP_FRONT) && !empty;
        ctrl.new_entry = new_entry;
        ctrl.count     = fill_reg;
        ctrl.tail_idx  = fill_reg - CNT_W'(1);
    end

    // The chain: slot zero is the front. On a push each cell at or past the insert
    // point takes its left neighbor's entry, and the first of them takes the new one.
    // On a pop front every cell takes its right neighbor's entry.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        entry_t left_entry;
        logic   left_after;
        entry_t right_entry;

        if (i == 0) begin : g_first
            assign left_entry = new_entry;
            assign left_after = 1'b0;
        end else begin : g_inner
            assign left_entry = cell_q[i-1];
            assign left_after = after_q[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_entry = cell_q[i];
        end else begin : g_mid
            assign right_entry = cell_q[i+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .idx         (CNT_W'(i)),
            .ctrl        (ctrl),
            .left_entry  (left_entry),
            .left_after  (left_after),
            .right_entry (right_entry),
            .cur_entry   (cell_q[i]),
            .after       (after_q[i]),
            .tail_leaf   (tail_leaf[i])
        );
    end

    // Only the back cell drives a nonzero leaf, so the OR of all leaves is the back entry.
    spq_tail_tree u_tail_tree (
        .aclk (aclk),
        .leaf (tail_leaf),
        .tail (tail_entry)
    );

    // Request control. Back requests wait in ST_WAIT until the tree output reflects
    // the current contents; nothing in the chain moves while they wait.
    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        wait_next     = wait_reg;
        pend_pop_next = pend_pop_reg;

        m_valid_next  = m_valid_reg && !m_ready;
        m_ok_next     = m_ok_reg;
        m_entry_next  = m_entry_reg;
        m_count_next  = m_count_reg;
        m_empty_next  = m_empty_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_req_type)
                        REQ_PUSH: begin
                            m_valid_next = 1'b1;
                            m_ok_next    = !full;
                            m_entry_next = full ? entry_t'('0) : new_entry;
                            fill_next    = full ? fill_reg : fill_reg + CNT_W'(1);
                        end
                        REQ_POP_FRONT: begin
                            m_valid_next = 1'b1;
                            m_ok_next    = !empty;
                            m_entry_next = empty ? entry_t'('0) : cell_q[0];
                            fill_next    = empty ? fill_reg : fill_reg - CNT_W'(1);
                        end
                        REQ_POP_BACK, REQ_PEEK_BACK: begin
                            if (empty) begin
                                m_valid_next = 1'b1;
                                m_ok_next    = 1'b0;
                                m_entry_next = '0;
                            end else begin
                                state_next    = ST_WAIT;
                                wait_next     = '0;
                                pend_pop_next = s_req_type == REQ_POP_BACK;
                            end
                        end
                        default: begin
                            m_valid_next = 1'b1;
                            m_ok_next    = 1'b0;
                            m_entry_next = '0;
                        end
                    endcase
                    m_count_next = count_field(fill_next);
                    m_empty_next = fill_next == '0;
                end
            end
            ST_WAIT: begin
                if (wait_reg == WAIT_W'(TREE_LEVELS)) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_ok_next    = 1'b1;
                        m_entry_next = tail_entry;
                        fill_next    = pend_pop_reg ? fill_reg - CNT_W'(1) : fill_reg;
                        m_count_next = count_field(fill_next);
                        m_empty_next = fill_next == '0;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    wait_next = wait_reg + WAIT_W'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            wait_reg     <= '0;
            pend_pop_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            wait_reg     <= wait_next;
            pend_pop_reg <= pend_pop_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_ok_reg    <= m_ok_next;
        m_entry_reg <= m_entry_next;
        m_count_reg <= m_count_next;
        m_empty_reg <= m_empty_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_ok           = m_ok_reg;
    assign m_out_entry    = m_entry_reg.id;
    assign m_out_priority = m_entry_reg.prio;
    assign m_count        = m_count_reg;
    assign m_empty_res    = m_empty_reg;

    // The entry count never passes the capacity of the chain.
    `SPQ_ASSERT(a_fill_in_range, fill_reg <= CNT_W'(CAPACITY), "entry count above capacity")

    // A pop front on a nonempty queue removes exactly one entry.
    `SPQ_ASSERT(a_pop_front_count, (s_fire && s_req_type == REQ_POP_FRONT && !empty) |=> (fill_reg == $past(fill_reg) - CNT_W'(1)), "pop front did not decrement count")

    // A push with room left reports success on the next cycle.
    `SPQ_ASSERT(a_push_ok, (s_fire && s_req_type == REQ_PUSH && !full) |=> (m_valid_reg && m_ok_reg), "accepted push not reported as success")

    // While a back request waits for the tree no other result is pending.
    `SPQ_ASSERT(a_wait_no_result, (state_reg == ST_WAIT) |-> !m_valid_reg, "result pending during back lookup")

    // Reset leaves the queue empty with no result pending.
    `SPQ_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> (fill_reg == '0 && !m_valid_reg && state_reg == ST_IDLE), "reset did not clear control state")

endmodule

/* rtl/core/spq_cell.sv */
// One storage cell of the sorted chain: holds one entry and shifts with its neighbors.
module spq_cell (
    input  logic                     aclk,
    input  logic [spq_pkg::CNT_W-1:0] idx,
    input  spq_pkg::cell_ctrl_t      ctrl,
    input  spq_pkg::entry_t          left_entry,
    input  logic                     left_after,
    input  spq_pkg::entry_t          right_entry,
    output spq_pkg::entry_t          cur_entry,
    output logic                     after,
    output spq_pkg::entry_t          tail_leaf
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   occupied;
    logic   beats;

    always_comb begin
        occupied = idx < ctrl.count;
        beats    = occupied && (ctrl.new_entry.prio > entry_reg.prio);
        // The list is sorted, so every cell at or past the insert point sees this.
        after    = beats || !occupied;

        entry_next = entry_reg;
        if (ctrl.push && after) begin
            entry_next = left_after ? left_entry : ctrl.new_entry;
        end else if (ctrl.pop_front) begin
            entry_next = right_entry;
        end

        tail_leaf = (idx == ctrl.tail_idx) ? entry_reg : '0;
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign cur_entry = entry_reg;

endmodule

/* rtl/core/spq_tail_tree.sv */
// Registered OR tree that collects the one entry flagged as the back of the queue.
module spq_tail_tree (
    input  logic            aclk,
    input  spq_pkg::entry_t leaf [spq_pkg::CAPACITY],
    output spq_pkg::entry_t tail
);
    import spq_pkg::*;

    logic [ENTRY_W-1:0] leaf_pad [TREE_LEAVES];
    logic [ENTRY_W-1:0] node_reg [TREE_LEVELS][TREE_NODES];

    always_comb begin
        for (int i = 0; i < TREE_LEAVES; i++) begin
            leaf_pad[i] = '0;
            if (i < CAPACITY) begin
                leaf_pad[i] = leaf[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < TREE_NODES; k++) begin
            logic [ENTRY_W-1:0] acc;
            acc = '0;
            for (int j = 0; j < TREE_FANIN; j++) begin
                acc = acc | leaf_pad[k * TREE_FANIN + j];
            end
            node_reg[0][k] <= acc;
        end
        for (int l = 1; l < TREE_LEVELS; l++) begin
            for (int k = 0; k < TREE_NODES; k++) begin
                logic [ENTRY_W-1:0] acc;
                acc = '0;
                for (int j = 0; j < TREE_FANIN; j++) begin
                    if (k * TREE_FANIN + j < TREE_NODES) begin
                        acc = acc | node_reg[l-1][k * TREE_FANIN + j];
                    end
                end
                node_reg[l][k] <= acc;
            end
        end
    end

    assign tail = node_reg[TREE_LEVELS-1][0];

endmodule
